// ----- rtl/ifdyu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// IMU frame decoder package
// Frame geometry, scaling constants and the decoded frame record shared by the
// capture stage, the yaw unwrap stage and the top level.
// ----------------------------------------------------------------------------
package ifdyu_pkg;

  localparam int FRAME_LEN  = 40;
  localparam int BUF_LEN    = 128;
  localparam int KEEP_FIRST = 16;
  localparam int KEEP_COUNT = 20;
  localparam int KEEP_IDX_W = $clog2(KEEP_COUNT);
  localparam int LEN_W      = 8;

  // Byte offsets of the little-endian words inside the kept window.
  localparam int OFS_GYRO_ROLL  = 16 - KEEP_FIRST;
  localparam int OFS_GYRO_PITCH = 18 - KEEP_FIRST;
  localparam int OFS_GYRO_YAW   = 20 - KEEP_FIRST;
  localparam int OFS_PITCH      = 30 - KEEP_FIRST;
  localparam int OFS_ROLL       = 32 - KEEP_FIRST;
  localparam int OFS_YAW        = 34 - KEEP_FIRST;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_IDLE = 1'b1;

  localparam int YAW_WRAP_THRESH   = 3000;
  localparam int TURN_DECIDEG      = 3600;
  localparam int VISION_PITCH_BIAS = 9000;
  localparam int VISION_YAW_BIAS   = 1800;
  localparam int DIV10_RECIP       = 52429;
  localparam int DIV10_SHIFT       = 19;

  localparam int VP_W   = 14;
  localparam int CONT_W = 28;

  typedef struct packed {
    logic signed [15:0]     gyro_roll;
    logic signed [15:0]     gyro_pitch;
    logic signed [15:0]     gyro_yaw;
    logic signed [15:0]     pitch;
    logic signed [15:0]     roll;
    logic signed [15:0]     yaw;
    logic signed [VP_W-1:0] vision_pitch;
  } frame_t;

endpackage
`default_nettype wire

// ----- rtl/ifdyu_frame_capture.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// IMU frame capture
// Counts the bytes of each burst, keeps the window of bytes that carry the
// words, and on line idle registers a decoded frame when the length is right.
// ----------------------------------------------------------------------------
module ifdyu_frame_capture (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic           kind,
  input  wire logic [7:0]     byte_value,
  input  wire logic           advance,
  output logic                frame_valid,
  output ifdyu_pkg::frame_t   frame
);
  import ifdyu_pkg::*;

  logic [LEN_W-1:0]      burst_length;
  logic [7:0]            frame_bytes [KEEP_COUNT];
  logic [LEN_W-1:0]      keep_ofs;
  logic                  in_window;
  logic                  take;
  frame_t                frame_next;
  logic signed [16:0]    vp_diff;
  logic                  vp_neg;
  logic [15:0]           vp_mag;
  logic [31:0]           vp_prod;
  logic [VP_W-2:0]       vp_quot;

  assign keep_ofs  = burst_length - LEN_W'(KEEP_FIRST);
  assign in_window = (burst_length >= LEN_W'(KEEP_FIRST)) &&
                     (burst_length < LEN_W'(KEEP_FIRST + KEEP_COUNT));
  assign take      = accept && (kind == KIND_IDLE) && (burst_length == LEN_W'(FRAME_LEN));

  always_comb begin
    frame_next.gyro_roll  = {frame_bytes[OFS_GYRO_ROLL + 1], frame_bytes[OFS_GYRO_ROLL]};
    frame_next.gyro_pitch = {frame_bytes[OFS_GYRO_PITCH + 1], frame_bytes[OFS_GYRO_PITCH]};
    frame_next.gyro_yaw   = {frame_bytes[OFS_GYRO_YAW + 1], frame_bytes[OFS_GYRO_YAW]};
    frame_next.pitch      = {frame_bytes[OFS_PITCH + 1], frame_bytes[OFS_PITCH]};
    frame_next.roll       = {frame_bytes[OFS_ROLL + 1], frame_bytes[OFS_ROLL]};
    frame_next.yaw        = {frame_bytes[OFS_YAW + 1], frame_bytes[OFS_YAW]};
    // Division by ten through the reciprocal, on the magnitude so that the
    // quotient truncates towards zero.
    vp_diff = 17'(VISION_PITCH_BIAS) - {frame_next.pitch[15], frame_next.pitch};
    vp_neg  = vp_diff[16];
    vp_mag  = vp_neg ? 16'(-vp_diff) : vp_diff[15:0];
    vp_prod = vp_mag * 32'(DIV10_RECIP);
    vp_quot = vp_prod[DIV10_SHIFT +: VP_W-1];
    frame_next.vision_pitch = vp_neg ? -$signed({1'b0, vp_quot}) : $signed({1'b0, vp_quot});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_length <= '0;
      frame_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (kind == KIND_BYTE) begin
          if (burst_length < LEN_W'(BUF_LEN)) begin
            burst_length <= burst_length + 1'b1;
          end
        end else begin
          burst_length <= '0;
        end
      end
      if (take) begin
        frame_valid <= 1'b1;
      end else if (advance) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_BYTE) && in_window) begin
      frame_bytes[keep_ofs[KEEP_IDX_W-1:0]] <= byte_value;
    end
    if (take) begin
      frame <= frame_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ifdyu_yaw_unwrap.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// IMU yaw unwrap and result register
// Tracks full yaw turns against the previous frame and registers the result
// fields, holding them while the output is stalled.
// ----------------------------------------------------------------------------
module ifdyu_yaw_unwrap (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             frame_valid,
  input  wire ifdyu_pkg::frame_t                frame,
  output logic                                  ready,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [15:0]                    gyro_roll,
  output logic signed [15:0]                    gyro_pitch,
  output logic signed [15:0]                    gyro_yaw,
  output logic signed [15:0]                    pitch_centideg,
  output logic signed [15:0]                    roll_centideg,
  output logic signed [15:0]                    yaw_decideg,
  output logic signed [ifdyu_pkg::CONT_W-1:0]   continuous_yaw_decideg,
  output logic signed [15:0]                    turn_count,
  output logic signed [ifdyu_pkg::VP_W-1:0]     vision_pitch,
  output logic signed [15:0]                    vision_yaw
);
  import ifdyu_pkg::*;

  logic signed [15:0]       previous_yaw;
  logic signed [15:0]       turns;
  logic signed [15:0]       turns_next;
  logic signed [16:0]       yaw_delta;
  logic                     step_down;
  logic                     step_up;
  logic signed [CONT_W-1:0] turns_scaled;
  logic                     load;

  assign ready = !out_valid || !out_stall;
  assign load  = frame_valid && ready;

  always_comb begin
    yaw_delta = {frame.yaw[15], frame.yaw} - {previous_yaw[15], previous_yaw};
    step_down = (yaw_delta > 17'sd3000) && (turns != 16'sh8000);
    step_up   = (yaw_delta < -17'sd3000) && (turns != 16'sh7fff);
    turns_next = turns;
    if (step_down) begin
      turns_next = turns - 16'sd1;
    end else if (step_up) begin
      turns_next = turns + 16'sd1;
    end
    turns_scaled = $signed({{(CONT_W-16){turns_next[15]}}, turns_next}) *
                   $signed(CONT_W'(TURN_DECIDEG));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      previous_yaw <= '0;
      turns        <= '0;
    end else begin
      if (load) begin
        out_valid    <= 1'b1;
        previous_yaw <= frame.yaw;
        turns        <= turns_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gyro_roll              <= frame.gyro_roll;
      gyro_pitch             <= frame.gyro_pitch;
      gyro_yaw               <= frame.gyro_yaw;
      pitch_centideg         <= frame.pitch;
      roll_centideg          <= frame.roll;
      yaw_decideg            <= frame.yaw;
      continuous_yaw_decideg <= $signed({{(CONT_W-16){frame.yaw[15]}}, frame.yaw}) +
                                turns_scaled;
      turn_count             <= turns_next;
      vision_pitch           <= frame.vision_pitch;
      vision_yaw             <= 16'(VISION_YAW_BIAS) - frame.yaw;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/imu_frame_decode_yaw_unwrap_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// IMU frame decoder with yaw unwrap
// Takes one request per cycle, either a received byte or a line idle event,
// and gives one result for each idle that closes a burst of exactly the
// frame length. A result passes first through the capture register, which
// loads at the edge that takes its idle request, and then through the result
// register, which loads when it is empty or its output is not stalled.
// Requests are taken every cycle unless both registers hold frames and the
// output is stalled, in which case the input stalls too.
// ----------------------------------------------------------------------------
module imu_frame_decode_yaw_unwrap_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             kind,
  input  wire logic [7:0]                       byte_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [15:0]                    gyro_roll,
  output logic signed [15:0]                    gyro_pitch,
  output logic signed [15:0]                    gyro_yaw,
  output logic signed [15:0]                    pitch_centideg,
  output logic signed [15:0]                    roll_centideg,
  output logic signed [15:0]                    yaw_decideg,
  output logic signed [ifdyu_pkg::CONT_W-1:0]   continuous_yaw_decideg,
  output logic signed [15:0]                    turn_count,
  output logic signed [ifdyu_pkg::VP_W-1:0]     vision_pitch,
  output logic signed [15:0]                    vision_yaw
);
  import ifdyu_pkg::*;

  logic   frame_valid;
  frame_t frame;
  logic   ready;
  logic   accept;
  logic   advance;

  assign in_stall = frame_valid && !ready;
  assign accept   = in_valid && !in_stall;
  assign advance  = frame_valid && ready;

  ifdyu_frame_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (kind),
    .byte_value  (byte_value),
    .advance     (advance),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  ifdyu_yaw_unwrap u_unwrap (
    .clk                    (clk),
    .rst                    (rst),
    .frame_valid            (frame_valid),
    .frame                  (frame),
    .ready                  (ready),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .gyro_roll              (gyro_roll),
    .gyro_pitch             (gyro_pitch),
    .gyro_yaw               (gyro_yaw),
    .pitch_centideg         (pitch_centideg),
    .roll_centideg          (roll_centideg),
    .yaw_decideg            (yaw_decideg),
    .continuous_yaw_decideg (continuous_yaw_decideg),
    .turn_count             (turn_count),
    .vision_pitch           (vision_pitch),
    .vision_yaw             (vision_yaw)
  );

endmodule
`default_nettype wire
